// ----- rtl/lgs_pkg.sv -----
package lgs_pkg;

    localparam int SAMPLE_W = 32;
    localparam int NUM_W    = 37;
    localparam int MAG_W    = 36;
    localparam int INV_W    = 32;
    localparam int LEN_W    = 11;
    localparam int POS_W    = 10;
    localparam int FORCE_W  = 32;
    localparam int CFG_W    = 32;
    localparam int PROD_W   = 68;
    localparam int QUOT_W   = 33;

    localparam int MAX_LINE_DEFAULT = 1024;
    localparam int QUEUE_DEPTH      = 4;

    localparam logic [LEN_W-1:0] LINE_LENGTH_RESET = 11'd1024;
    localparam logic [INV_W-1:0] INV_DX_RESET      = 32'h0001_0000;

    // Configuration register indexes.
    localparam logic CFG_LINE_LENGTH = 1'b0;
    localparam logic CFG_INV_DX      = 1'b1;

    // Which difference a job carries, and therefore which divisor applies.
    typedef enum logic [1:0] {
        KIND_INTERIOR,
        KIND_NEAR,
        KIND_EDGE
    } kind_t;

    typedef struct packed {
        logic signed [NUM_W-1:0] num;
        kind_t                   kind;
        logic [POS_W-1:0]        pos;
        logic                    last_of_run;
        logic                    line_done;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ----- rtl/lgs_ifs.sv -----
interface lgs_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [lgs_pkg::SAMPLE_W-1:0]    sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface lgs_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [lgs_pkg::FORCE_W-1:0]     force_res;
    logic [lgs_pkg::POS_W-1:0]              position;
    logic                                   last_of_run;
    logic                                   line_done;

    modport source (output valid, output force_res, output position,
                    output last_of_run, output line_done, input ready);
    modport sink (input valid, input force_res, input position,
                  input last_of_run, input line_done, output ready);
endinterface

// ----- rtl/lgs_front.sv -----
module lgs_front #(
    parameter int MAX_LINE = lgs_pkg::MAX_LINE_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    lgs_in_if.sink                      samples,
    input  logic [lgs_pkg::LEN_W-1:0]   line_length,
    input  lgs_pkg::q_stat_t            qstat,
    output logic                        push,
    output lgs_pkg::job_t               job
);

    localparam int PW = $clog2(MAX_LINE);
    localparam int CW = (PW + 1 > lgs_pkg::LEN_W) ? PW + 1 : lgs_pkg::LEN_W;
    localparam logic [CW-1:0] LEN_MIN = CW'(4);
    localparam logic [CW-1:0] LEN_MAX = CW'(MAX_LINE);

    typedef enum logic [1:0] {
        STEP_MAIN,
        STEP_NEAR,
        STEP_EDGE
    } step_t;

    logic signed [lgs_pkg::SAMPLE_W-1:0] win_reg [5];
    logic [PW-1:0]  pos_reg;
    logic           pend_valid_reg;
    step_t          pend_step_reg;
    logic           pend_last_reg;
    logic [PW-1:0]  pend_i_reg;

    logic [CW-1:0]  len_raw;
    logic [CW-1:0]  len_c;
    logic           last_c;
    logic           accept;
    logic           final_c;

    logic signed [32:0] d31;
    logic signed [32:0] d40;
    logic signed [32:0] d20;
    logic signed [32:0] d10;
    logic signed [32:0] d21;
    logic signed [lgs_pkg::NUM_W-1:0] num_int;
    logic [PW-1:0]          p_c;
    logic [PW+lgs_pkg::POS_W-1:0] p_ext;

    assign len_raw = CW'(line_length);

    always_comb
    begin
        if (len_raw < LEN_MIN)
        begin
            len_c = LEN_MIN;
        end
        else if (len_raw > LEN_MAX)
        begin
            len_c = LEN_MAX;
        end
        else
        begin
            len_c = len_raw;
        end
    end

    assign last_c  = (CW'(pos_reg) + CW'(1)) >= len_c;
    assign push    = pend_valid_reg && !qstat.full;
    assign final_c = (pend_step_reg == STEP_EDGE) ||
                     (pend_step_reg == STEP_MAIN && !pend_last_reg);

    // A new sample may enter once the current one has handed over its last job.
    assign samples.ready = !pend_valid_reg || (push && final_c);
    assign accept        = samples.valid && samples.ready;

    // The window holds the newest sample in entry 0.
    assign d31 = {win_reg[3][31], win_reg[3]} - {win_reg[1][31], win_reg[1]};
    assign d40 = {win_reg[4][31], win_reg[4]} - {win_reg[0][31], win_reg[0]};
    assign d20 = {win_reg[2][31], win_reg[2]} - {win_reg[0][31], win_reg[0]};
    assign d10 = {win_reg[1][31], win_reg[1]} - {win_reg[0][31], win_reg[0]};
    assign d21 = {win_reg[2][31], win_reg[2]} - {win_reg[1][31], win_reg[1]};
    assign num_int = {d31[32], d31, 3'b000} - {{4{d40[32]}}, d40};

    always_comb
    begin
        job.last_of_run = 1'b0;
        job.line_done   = 1'b0;
        p_c             = pend_i_reg;
        unique case (pend_step_reg)
            STEP_MAIN:
            begin
                p_c             = pend_i_reg - PW'(2);
                job.last_of_run = !pend_last_reg;
                if (pend_i_reg == PW'(2))
                begin
                    job.kind = lgs_pkg::KIND_EDGE;
                    job.num  = {{4{d21[32]}}, d21};
                end
                else if (pend_i_reg == PW'(3))
                begin
                    job.kind = lgs_pkg::KIND_NEAR;
                    job.num  = {{4{d31[32]}}, d31};
                end
                else
                begin
                    job.kind = lgs_pkg::KIND_INTERIOR;
                    job.num  = num_int;
                end
            end
            STEP_NEAR:
            begin
                p_c      = pend_i_reg - PW'(1);
                job.kind = lgs_pkg::KIND_NEAR;
                job.num  = {{4{d20[32]}}, d20};
            end
            STEP_EDGE:
            begin
                job.kind        = lgs_pkg::KIND_EDGE;
                job.num         = {{4{d10[32]}}, d10};
                job.last_of_run = 1'b1;
                job.line_done   = 1'b1;
            end
            default:
            begin
                job.kind = lgs_pkg::KIND_EDGE;
                job.num  = '0;
            end
        endcase
        p_ext   = (PW + lgs_pkg::POS_W)'(p_c);
        job.pos = p_ext[lgs_pkg::POS_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            win_reg[0] <= samples.sample;
            for (int k = 1; k < 5; k++)
            begin
                win_reg[k] <= win_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            pend_valid_reg <= 1'b0;
            pend_step_reg  <= STEP_MAIN;
            pend_last_reg  <= 1'b0;
            pend_i_reg     <= '0;
        end
        else if (accept)
        begin
            pos_reg        <= last_c ? '0 : pos_reg + PW'(1);
            pend_valid_reg <= pos_reg >= PW'(2);
            pend_step_reg  <= STEP_MAIN;
            pend_last_reg  <= last_c;
            pend_i_reg     <= pos_reg;
        end
        else if (push)
        begin
            if (final_c)
            begin
                pend_valid_reg <= 1'b0;
            end
            else if (pend_step_reg == STEP_MAIN)
            begin
                pend_step_reg <= STEP_NEAR;
            end
            else
            begin
                pend_step_reg <= STEP_EDGE;
            end
        end
    end

    a_pend_has_window: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> pend_i_reg >= PW'(2))
        else $error("front holds a job before two samples of the line arrived");

    a_flush_after_three: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg && pend_last_reg |-> pend_i_reg >= PW'(3))
        else $error("line ended before four samples");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(pos_reg) < LEN_MAX)
        else $error("line position beyond the longest line");

endmodule

// ----- rtl/lgs_queue.sv -----
module lgs_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  lgs_pkg::job_t       wr_job,
    input  logic                pop,
    output lgs_pkg::job_t       rd_job,
    output lgs_pkg::q_stat_t    qstat
);

    localparam int AW = $clog2(lgs_pkg::QUEUE_DEPTH);

    lgs_pkg::job_t  slot_reg [lgs_pkg::QUEUE_DEPTH];
    logic [AW-1:0]  wr_ptr_reg;
    logic [AW-1:0]  rd_ptr_reg;
    logic [AW:0]    count_reg;
    logic           do_push;
    logic           do_pop;

    assign qstat.full  = count_reg == (AW + 1)'(lgs_pkg::QUEUE_DEPTH);
    assign qstat.empty = count_reg == '0;
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign rd_job      = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + (AW + 1)'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - (AW + 1)'(1);
            end
        end
    end

endmodule

// ----- rtl/lgs_back.sv -----
module lgs_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lgs_pkg::job_t               job,
    input  lgs_pkg::q_stat_t            qstat,
    input  logic [lgs_pkg::INV_W-1:0]   inv_dx,
    output logic                        pop,
    lgs_out_if.source                   forces
);

    localparam logic [lgs_pkg::PROD_W-1:0] BIAS_INTERIOR = 68'd393216;
    localparam logic [lgs_pkg::PROD_W-1:0] BIAS_NEAR     = 68'd65536;
    localparam logic [lgs_pkg::PROD_W-1:0] BIAS_EDGE     = 68'd32768;
    localparam logic [49:0]  SAT_THIRD = 50'd6442450944;
    localparam logic [30:0]  RECIP3    = 31'h5555_5555;

    typedef struct packed {
        logic                       neg;
        lgs_pkg::kind_t             kind;
        logic [lgs_pkg::POS_W-1:0]  pos;
        logic                       last_of_run;
        logic                       line_done;
    } meta_t;

    logic                        adv;

    logic                        s1_valid_reg;
    meta_t                       s1_meta_reg;
    logic [lgs_pkg::MAG_W-1:0]   s1_mag_reg;

    logic                        s2_valid_reg;
    meta_t                       s2_meta_reg;
    logic [63:0]                 s2_pp_lo_reg;
    logic [35:0]                 s2_pp_hi_reg;

    logic                        s3_valid_reg;
    meta_t                       s3_meta_reg;
    logic [lgs_pkg::QUOT_W-1:0]  s3_t_reg;
    logic                        s3_sat_reg;

    logic                        s4_valid_reg;
    meta_t                       s4_meta_reg;
    logic [lgs_pkg::QUOT_W-1:0]  s4_t_reg;
    logic                        s4_sat_reg;
    logic [63:0]                 s4_prod_reg;

    logic                        s5_valid_reg;
    meta_t                       s5_meta_reg;
    logic [lgs_pkg::FORCE_W-1:0] s5_force_reg;

    logic signed [lgs_pkg::NUM_W-1:0] num_neg;
    logic [lgs_pkg::MAG_W-1:0]   mag_c;
    logic [lgs_pkg::PROD_W-1:0]  sum_c;
    logic [lgs_pkg::QUOT_W-1:0]  t_c;
    logic                        sat_c;
    logic [63:0]                 prod3_c;
    logic [30:0]                 q0_c;
    logic [lgs_pkg::QUOT_W-1:0]  three_q_c;
    logic [lgs_pkg::QUOT_W-1:0]  rem_c;
    logic [30:0]                 q_c;
    logic [lgs_pkg::FORCE_W-1:0] force_c;

    // The whole pipeline moves together whenever the output register can take a result.
    assign adv = !s5_valid_reg || forces.ready;
    assign pop = adv && !qstat.empty;

    assign num_neg = -job.num;
    assign mag_c   = job.num[lgs_pkg::NUM_W-1] ? num_neg[lgs_pkg::MAG_W-1:0]
                                               : job.num[lgs_pkg::MAG_W-1:0];

    // Rounded quotient = (product + divisor/2) / divisor; divide by 12 is a shift then by 3.
    always_comb
    begin
        sum_c = {s2_pp_hi_reg, 32'b0} + {4'b0, s2_pp_lo_reg};
        unique case (s2_meta_reg.kind)
            lgs_pkg::KIND_INTERIOR:
            begin
                sum_c = sum_c + BIAS_INTERIOR;
                sat_c = sum_c[67:18] >= SAT_THIRD;
                t_c   = sum_c[50:18];
            end
            lgs_pkg::KIND_NEAR:
            begin
                sum_c = sum_c + BIAS_NEAR;
                sat_c = |sum_c[67:48];
                t_c   = {2'b00, sum_c[47:17]};
            end
            lgs_pkg::KIND_EDGE:
            begin
                sum_c = sum_c + BIAS_EDGE;
                sat_c = |sum_c[67:47];
                t_c   = {2'b00, sum_c[46:16]};
            end
            default:
            begin
                sat_c = 1'b0;
                t_c   = '0;
            end
        endcase
    end

    assign prod3_c = {31'b0, s3_t_reg} * {33'b0, RECIP3};

    // The reciprocal estimate is at most one low; one compare fixes it.
    assign q0_c      = s4_prod_reg[62:32];
    assign three_q_c = {1'b0, q0_c, 1'b0} + {2'b00, q0_c};
    assign rem_c     = s4_t_reg - three_q_c;

    always_comb
    begin
        if (s4_meta_reg.kind == lgs_pkg::KIND_INTERIOR)
        begin
            q_c = (rem_c >= 33'd3) ? q0_c + 31'd1 : q0_c;
        end
        else
        begin
            q_c = s4_t_reg[30:0];
        end

        if (s4_sat_reg)
        begin
            force_c = s4_meta_reg.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else if (s4_meta_reg.neg)
        begin
            force_c = 32'd0 - {1'b0, q_c};
        end
        else
        begin
            force_c = {1'b0, q_c};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_meta_reg.neg         <= job.num[lgs_pkg::NUM_W-1];
            s1_meta_reg.kind        <= job.kind;
            s1_meta_reg.pos         <= job.pos;
            s1_meta_reg.last_of_run <= job.last_of_run;
            s1_meta_reg.line_done   <= job.line_done;
            s1_mag_reg              <= mag_c;

            s2_meta_reg  <= s1_meta_reg;
            s2_pp_lo_reg <= {32'b0, s1_mag_reg[31:0]} * {32'b0, inv_dx};
            s2_pp_hi_reg <= {32'b0, s1_mag_reg[35:32]} * {4'b0, inv_dx};

            s3_meta_reg <= s2_meta_reg;
            s3_t_reg    <= t_c;
            s3_sat_reg  <= sat_c;

            s4_meta_reg <= s3_meta_reg;
            s4_t_reg    <= s3_t_reg;
            s4_sat_reg  <= s3_sat_reg;
            s4_prod_reg <= prod3_c;

            s5_meta_reg  <= s4_meta_reg;
            s5_force_reg <= force_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= !qstat.empty;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    assign forces.valid       = s5_valid_reg;
    assign forces.force_res   = s5_force_reg;
    assign forces.position    = s5_meta_reg.pos;
    assign forces.last_of_run = s5_meta_reg.last_of_run;
    assign forces.line_done   = s5_meta_reg.line_done;

    a_third_correction: assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid_reg && !s4_sat_reg && s4_meta_reg.kind == lgs_pkg::KIND_INTERIOR
        |-> rem_c < 33'd6)
        else $error("divide-by-three estimate off by more than one");

    a_line_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        s5_valid_reg && s5_meta_reg.line_done |-> s5_meta_reg.last_of_run)
        else $error("line end result is not the last of its run");

endmodule

// ----- rtl/line_gradient_stencil.sv -----
// Streaming negative first derivative of a potential along grid lines.
// Samples (signed Q16.16) enter on the samples channel, one per transfer, in
// order along a line of line_length samples; results leave on the forces
// channel with their position in the line, a last_of_run mark on the final
// result caused by a sample and line_done on the last position of a line.
// Interior positions use the five-point fourth-order stencil, the positions
// next to the edges a centered difference and the edges a one-sided one.
// Throughput is one sample per cycle unless a line end or full queue stalls it.
// The result for position p follows sample p+2; a line's last sample yields
// three results and stalls the input until all are queued. The output path is
// a five-stage pipeline (split multiply, rounding, divide by three) fed from a
// four-entry job queue, so a stalled receiver first fills the queue and then
// holds the input back; nothing is dropped. Configuration (line_length, inv_dx)
// is written through cfg_wr_en, cfg_index and cfg_wdata, by the user only
// while idle; the block does not enforce this. Reset clears the line position,
// the queue and the pipeline, and loads line_length 1024 and inv_dx 1.0.
module line_gradient_stencil #(
    parameter int MAX_LINE = lgs_pkg::MAX_LINE_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    lgs_in_if.sink                      samples,
    lgs_out_if.source                   forces,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_index,
    input  logic [lgs_pkg::CFG_W-1:0]   cfg_wdata
);

    logic [lgs_pkg::LEN_W-1:0] line_length_reg;
    logic [lgs_pkg::INV_W-1:0] inv_dx_reg;

    lgs_pkg::job_t      wr_job;
    lgs_pkg::job_t      rd_job;
    lgs_pkg::q_stat_t   qstat;
    logic               push;
    logic               pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_length_reg <= lgs_pkg::LINE_LENGTH_RESET;
            inv_dx_reg      <= lgs_pkg::INV_DX_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                lgs_pkg::CFG_LINE_LENGTH: line_length_reg <= cfg_wdata[lgs_pkg::LEN_W-1:0];
                lgs_pkg::CFG_INV_DX:      inv_dx_reg      <= cfg_wdata[lgs_pkg::INV_W-1:0];
                default:                  inv_dx_reg      <= inv_dx_reg;
            endcase
        end
    end

    lgs_front #(
        .MAX_LINE (MAX_LINE)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .samples     (samples),
        .line_length (line_length_reg),
        .qstat       (qstat),
        .push        (push),
        .job         (wr_job)
    );

    lgs_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (wr_job),
        .pop    (pop),
        .rd_job (rd_job),
        .qstat  (qstat)
    );

    lgs_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .job    (rd_job),
        .qstat  (qstat),
        .inv_dx (inv_dx_reg),
        .pop    (pop),
        .forces (forces)
    );

endmodule
